/* hw/rtl/dof_pkg.sv */
// Shared types and constants for the DHCPv6 option finder.
// No dependencies; every other file of the block refers to this package.
package dof_pkg;

    // Field widths of the byte stream and of the result
    localparam int DATA_W      = 8;
    localparam int MSG_LEN_W   = 12;
    localparam int OFFSET_W    = 11;
    localparam int OPT_LEN_W   = 11;
    localparam int CODE_W      = 16;
    localparam int HDR_W       = 32;

    // Option start never passes message_length, so it fits the length width
    localparam int START_W     = MSG_LEN_W;
    // Start plus header plus a full 16-bit option length
    localparam int END_W       = 17;

    // Default upper bound on byte positions that are examined
    localparam int MAX_MESSAGE_BYTES_DEF = 2048;

    // Option walk starts right after the type/transaction-id header
    localparam logic [START_W-1:0] FIRST_OPTION_START = START_W'(4);

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_FOUND     = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_MALFORMED = 2'd2
    } status_t;

    // One result item on its way from the walker to the output buffer
    typedef struct packed {
        status_t               status;
        logic [OFFSET_W-1:0]   option_offset;
        logic [OPT_LEN_W-1:0]  option_length;
    } result_t;

endpackage

/* hw/rtl/dof_if.sv */
// Valid/ready channel interfaces for the DHCPv6 option finder.
// Depends on dof_pkg for the field widths.

// Message byte channel
interface dof_in_if;
    logic                           valid;
    logic                           ready;
    logic [dof_pkg::DATA_W-1:0]     data_byte;
    logic [dof_pkg::MSG_LEN_W-1:0]  message_length;
    logic                           last_byte;

    modport source (output valid, output data_byte, output message_length,
                    output last_byte, input ready);
    modport sink   (input valid, input data_byte, input message_length,
                    input last_byte, output ready);
endinterface

// Search result channel
interface dof_out_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     status;
    logic [dof_pkg::OFFSET_W-1:0]   option_offset;
    logic [dof_pkg::OPT_LEN_W-1:0]  option_length;

    modport source (output valid, output status, output option_offset,
                    output option_length, input ready);
    modport sink   (input valid, input status, input option_offset,
                    input option_length, output ready);
endinterface

/* hw/rtl/dhcpv6_option_finder.sv */
// Latency: a result shows on out_stream in the cycle after its last byte is accepted,
// or later, once the results ahead of it have drained while the receiver stalls.
// Throughput: one byte per cycle; the walker decides each option header on its fourth byte.
// in_stream.ready drops only while both output register and skid slot hold results.
// Reset (rst_n low, asynchronous): walk restarts at offset 4, target_code clears to 0,
// output channel empties.
module dhcpv6_option_finder #(
    parameter int MAX_MESSAGE_BYTES = dof_pkg::MAX_MESSAGE_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [dof_pkg::CODE_W-1:0]    cfg_write_data,
    dof_in_if.sink                        in_stream,
    dof_out_if.source                     out_stream
);

    logic [dof_pkg::CODE_W-1:0]  target_code_reg;
    logic                        accept;
    logic                        can_push;
    logic                        result_valid;
    dof_pkg::result_t            result;

    // Hold the searched option code
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_code_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            target_code_reg <= cfg_write_data;
        end
    end

    // Take a byte whenever the result path has room
    assign in_stream.ready = can_push;
    assign accept          = in_stream.valid && can_push;

    dof_walker #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_walker (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .data_byte      (in_stream.data_byte),
        .message_length (in_stream.message_length),
        .last_byte      (in_stream.last_byte),
        .target_code    (target_code_reg),
        .result_valid   (result_valid),
        .result         (result)
    );

    dof_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (result_valid),
        .push_data  (result),
        .can_push   (can_push),
        .out_stream (out_stream)
    );

    // A result is produced only on an accepted last byte
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (in_stream.valid && in_stream.ready && in_stream.last_byte))
    else $error("result without an accepted last byte");

    // Input stalls only while a result is waiting at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_stream.ready |-> out_stream.valid)
    else $error("input stalled with empty output");

    // Offset and length are zero unless the option was found
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_stream.valid && (out_stream.status != dof_pkg::STATUS_FOUND))
        |-> (out_stream.option_offset == '0 && out_stream.option_length == '0))
    else $error("nonzero option fields on a not-found result");

    // After an accepted last byte the output holds a valid result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_stream.valid && in_stream.ready && in_stream.last_byte) |=> out_stream.valid)
    else $error("result missing after last byte");

endmodule

/* hw/rtl/dof_walker.sv */
// Per-byte option walk: position counter, header shift register and the
// option decision. Emits one result on the last byte of each message.
// Depends on dof_pkg.
module dof_walker #(
    parameter int MAX_MESSAGE_BYTES = dof_pkg::MAX_MESSAGE_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [dof_pkg::DATA_W-1:0]      data_byte,
    input  logic [dof_pkg::MSG_LEN_W-1:0]   message_length,
    input  logic                            last_byte,
    input  logic [dof_pkg::CODE_W-1:0]      target_code,
    output logic                            result_valid,
    output dof_pkg::result_t                result
);

    localparam int POS_W = $clog2(MAX_MESSAGE_BYTES + 1);
    // Compare width wide enough for position and start plus header
    localparam int CMP_W = (POS_W > dof_pkg::START_W + 1) ? POS_W : dof_pkg::START_W + 1;

    logic [POS_W-1:0]                pos_reg, pos_next;
    logic [dof_pkg::START_W-1:0]     start_reg, start_next;
    logic [dof_pkg::HDR_W-1:0]       shift_reg, shift_next;
    logic                            done_reg, done_next;
    dof_pkg::status_t                held_status_reg, held_status_next;
    logic [dof_pkg::OFFSET_W-1:0]    held_offset_reg, held_offset_next;
    logic [dof_pkg::OPT_LEN_W-1:0]   held_length_reg, held_length_next;

    logic [CMP_W-1:0]                pos_ext;
    logic [CMP_W-1:0]                start_ext;
    logic                            in_header;
    logic                            decide;
    logic [dof_pkg::HDR_W-1:0]       shift_upd;
    logic [dof_pkg::CODE_W-1:0]      opt_code;
    logic [15:0]                     opt_len;
    logic [dof_pkg::START_W:0]       hdr_end;
    logic [dof_pkg::END_W-1:0]       opt_end;
    logic [dof_pkg::END_W-1:0]       msg_len_ext;

    // Locate the current byte against the option header window
    always_comb
    begin
        pos_ext   = CMP_W'(pos_reg);
        start_ext = CMP_W'(start_reg);
        in_header = !done_reg
                    && (pos_reg < POS_W'(MAX_MESSAGE_BYTES))
                    && (pos_ext >= start_ext)
                    && (pos_ext < start_ext + CMP_W'(4));
        decide    = in_header && (pos_ext == start_ext + CMP_W'(3));
        shift_upd = in_header ? {shift_reg[dof_pkg::HDR_W-9:0], data_byte} : shift_reg;
        opt_code  = shift_upd[31:16];
        opt_len   = shift_upd[15:0];
        hdr_end   = {1'b0, start_reg} + (dof_pkg::START_W+1)'(4);
        opt_end   = dof_pkg::END_W'(hdr_end) + dof_pkg::END_W'(opt_len);
        msg_len_ext = dof_pkg::END_W'(message_length);
    end

    // Decide on a complete option header and advance the walk
    always_comb
    begin
        done_next        = done_reg;
        held_status_next = held_status_reg;
        held_offset_next = held_offset_reg;
        held_length_next = held_length_reg;
        start_next       = start_reg;
        if (decide)
        begin
            priority if (!((dof_pkg::START_W+1)'(message_length) > hdr_end))
            begin
                done_next        = 1'b1;
                held_status_next = dof_pkg::STATUS_NOT_FOUND;
            end
            else if (opt_len == 16'd0)
            begin
                done_next        = 1'b1;
                held_status_next = dof_pkg::STATUS_NOT_FOUND;
            end
            else if (opt_end > msg_len_ext)
            begin
                done_next        = 1'b1;
                held_status_next = dof_pkg::STATUS_MALFORMED;
            end
            else if (opt_code == target_code)
            begin
                done_next        = 1'b1;
                held_status_next = dof_pkg::STATUS_FOUND;
                held_offset_next = start_reg[dof_pkg::OFFSET_W-1:0];
                held_length_next = opt_len[dof_pkg::OPT_LEN_W-1:0];
            end
            else
            begin
                start_next = opt_end[dof_pkg::START_W-1:0];
            end
        end
        pos_next   = (pos_reg < POS_W'(MAX_MESSAGE_BYTES)) ? pos_reg + POS_W'(1) : pos_reg;
        shift_next = shift_upd;
    end

    // Form the result from the state after this byte
    always_comb
    begin
        result_valid = accept && last_byte;
        if (done_next && (held_status_next == dof_pkg::STATUS_FOUND))
        begin
            result.status        = dof_pkg::STATUS_FOUND;
            result.option_offset = held_offset_next;
            result.option_length = held_length_next;
        end
        else
        begin
            result.status        = done_next ? held_status_next : dof_pkg::STATUS_NOT_FOUND;
            result.option_offset = '0;
            result.option_length = '0;
        end
    end

    // Advance walk state per accepted byte; clear after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            start_reg       <= dof_pkg::FIRST_OPTION_START;
            shift_reg       <= '0;
            done_reg        <= 1'b0;
            held_status_reg <= dof_pkg::STATUS_NOT_FOUND;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                pos_reg         <= '0;
                start_reg       <= dof_pkg::FIRST_OPTION_START;
                shift_reg       <= '0;
                done_reg        <= 1'b0;
                held_status_reg <= dof_pkg::STATUS_NOT_FOUND;
            end
            else
            begin
                pos_reg         <= pos_next;
                start_reg       <= start_next;
                shift_reg       <= shift_next;
                done_reg        <= done_next;
                held_status_reg <= held_status_next;
            end
        end
    end

    // Hold found option details; read only while a found status is held
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_offset_reg <= held_offset_next;
            held_length_reg <= held_length_next;
        end
    end

endmodule

/* hw/rtl/dof_out_buf.sv */
// Output register with a skid slot for search results.
// Depends on dof_pkg and the dof_out_if interface.
module dof_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dof_pkg::result_t  push_data,
    output logic              can_push,
    dof_out_if.source         out_stream
);

    logic              out_valid_reg, out_valid_next;
    dof_pkg::result_t  out_data_reg, out_data_next;
    logic              skid_valid_reg, skid_valid_next;
    dof_pkg::result_t  skid_data_reg, skid_data_next;
    logic              drain;

    // Accept a new item whenever the skid slot is free
    assign can_push = !skid_valid_reg;

    // Route new items to the output register or skid slot; move the skid item to the output
    always_comb
    begin
        drain           = !out_valid_reg || out_stream.ready;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (drain)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push ? push_data : out_data_reg;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // Drive the result channel
    assign out_stream.valid         = out_valid_reg;
    assign out_stream.status        = out_data_reg.status;
    assign out_stream.option_offset = out_data_reg.option_offset;
    assign out_stream.option_length = out_data_reg.option_length;

endmodule
